// ----- rtl/ppi_pkg.sv -----
`timescale 1ns / 1ps

package ppi_pkg;

    // Field and intermediate widths. Coordinates are Q8.8, products Q16.16,
    // numerators Q24.24.
    localparam int CW    = 16;  // coordinate and normal field width
    localparam int DW    = 33;  // cross product component, Q16.16
    localparam int DDW   = 34;  // plane constant d = -(n . p)
    localparam int THW   = 33;  // parallel threshold
    localparam int PW    = 32;  // point output width
    localparam int PRW   = 50;  // d * n product
    localparam int NW    = 51;  // numerator (difference of two products)
    localparam int NMAG  = 50;  // numerator magnitude bits, one divider step each
    localparam int DMAG  = 32;  // divisor magnitude bits
    localparam int DIV_LAT = NMAG + 2;

    // Queue between the front and the back.
    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    // APB register map, one 64-bit register per 8 bytes.
    localparam int AW     = 6;
    localparam int RW     = 64;
    localparam logic [2:0] REG_REF_POINT_X  = 3'd0;
    localparam logic [2:0] REG_REF_POINT_Y  = 3'd1;
    localparam logic [2:0] REG_REF_POINT_Z  = 3'd2;
    localparam logic [2:0] REG_REF_NORMAL_X = 3'd3;
    localparam logic [2:0] REG_REF_NORMAL_Y = 3'd4;
    localparam logic [2:0] REG_REF_NORMAL_Z = 3'd5;
    localparam logic [2:0] REG_THRESHOLD    = 3'd6;

    // Relation codes.
    localparam logic [1:0] REL_DISJOINT   = 2'd0;
    localparam logic [1:0] REL_COINCIDENT = 2'd1;
    localparam logic [1:0] REL_LINE       = 2'd2;

    // Axis that is set to zero when solving for the point on the line.
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // Reference plane and threshold as held in the configuration registers.
    typedef struct packed {
        logic signed [CW-1:0] px;
        logic signed [CW-1:0] py;
        logic signed [CW-1:0] pz;
        logic signed [CW-1:0] nx;
        logic signed [CW-1:0] ny;
        logic signed [CW-1:0] nz;
        logic [THW-1:0]       thr;
    } ppi_ref_t;

    // Classified item passed from the front to the back.
    typedef struct packed {
        logic [1:0]            rel;
        logic [1:0]            axis;
        logic signed [DW-1:0]  ux;
        logic signed [DW-1:0]  uy;
        logic signed [DW-1:0]  uz;
        logic signed [DW-1:0]  den;
        logic signed [DDW-1:0] d0a;
        logic signed [DDW-1:0] d0b;
        logic signed [DDW-1:0] d1a;
        logic signed [DDW-1:0] d1b;
        logic signed [CW-1:0]  n0a;
        logic signed [CW-1:0]  n0b;
        logic signed [CW-1:0]  n1a;
        logic signed [CW-1:0]  n1b;
    } ppi_item_t;

    // Side data that travels alongside the dividers.
    typedef struct packed {
        logic [1:0]           rel;
        logic [1:0]           axis;
        logic signed [DW-1:0] ux;
        logic signed [DW-1:0] uy;
        logic signed [DW-1:0] uz;
    } ppi_side_t;

endpackage

// ----- rtl/ppi_front.sv -----
`timescale 1ns / 1ps

module ppi_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  ppi_pkg::ppi_ref_t             cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [ppi_pkg::CW-1:0] bpx,
    input  logic signed [ppi_pkg::CW-1:0] bpy,
    input  logic signed [ppi_pkg::CW-1:0] bpz,
    input  logic signed [ppi_pkg::CW-1:0] bnx,
    input  logic signed [ppi_pkg::CW-1:0] bny,
    input  logic signed [ppi_pkg::CW-1:0] bnz,
    output logic                          out_valid,
    input  logic                          out_ready,
    output ppi_pkg::ppi_item_t            out_item
);

    logic en;
    logic v1_reg, v2_reg, v3_reg;

    // Stage 1: input item and point differences.
    logic signed [ppi_pkg::CW-1:0] bnx1_reg, bny1_reg, bnz1_reg;
    logic signed [ppi_pkg::CW-1:0] bpx1_reg, bpy1_reg, bpz1_reg;
    logic signed [ppi_pkg::CW:0]   dx1_reg, dy1_reg, dz1_reg;

    // Stage 2: products.
    logic signed [ppi_pkg::CW-1:0]   bnx2_reg, bny2_reg, bnz2_reg;
    logic signed [2*ppi_pkg::CW-1:0] c0_reg, c1_reg, c2_reg, c3_reg, c4_reg, c5_reg;
    logic signed [2*ppi_pkg::CW:0]   t0_reg, t1_reg, t2_reg;
    logic signed [2*ppi_pkg::CW-1:0] a0_reg, a1_reg, a2_reg;
    logic signed [2*ppi_pkg::CW-1:0] b0_reg, b1_reg, b2_reg;

    // Stage 3: cross product, dot product and plane constants.
    logic signed [ppi_pkg::CW-1:0]  bnx3_reg, bny3_reg, bnz3_reg;
    logic signed [ppi_pkg::DW-1:0]  ux3_reg, uy3_reg, uz3_reg;
    logic signed [2*ppi_pkg::CW+2:0] dot3_reg;
    logic signed [ppi_pkg::DDW-1:0] d1_3_reg, d2_3_reg;

    // The whole front advances together when its last stage can drain.
    assign en       = !v3_reg || out_ready;
    assign in_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Stage 1 registers.
    always_ff @(posedge aclk) begin
        if (en) begin
            bnx1_reg <= bnx;
            bny1_reg <= bny;
            bnz1_reg <= bnz;
            bpx1_reg <= bpx;
            bpy1_reg <= bpy;
            bpz1_reg <= bpz;
            dx1_reg  <= (ppi_pkg::CW+1)'(bpx) - (ppi_pkg::CW+1)'(cfg.px);
            dy1_reg  <= (ppi_pkg::CW+1)'(bpy) - (ppi_pkg::CW+1)'(cfg.py);
            dz1_reg  <= (ppi_pkg::CW+1)'(bpz) - (ppi_pkg::CW+1)'(cfg.pz);
        end
    end

    // Stage 2: all products of the cross product, dot product and constants.
    always_ff @(posedge aclk) begin
        if (en) begin
            bnx2_reg <= bnx1_reg;
            bny2_reg <= bny1_reg;
            bnz2_reg <= bnz1_reg;
            c0_reg   <= cfg.ny * bnz1_reg;
            c1_reg   <= cfg.nz * bny1_reg;
            c2_reg   <= cfg.nz * bnx1_reg;
            c3_reg   <= cfg.nx * bnz1_reg;
            c4_reg   <= cfg.nx * bny1_reg;
            c5_reg   <= cfg.ny * bnx1_reg;
            t0_reg   <= cfg.nx * dx1_reg;
            t1_reg   <= cfg.ny * dy1_reg;
            t2_reg   <= cfg.nz * dz1_reg;
            a0_reg   <= cfg.nx * cfg.px;
            a1_reg   <= cfg.ny * cfg.py;
            a2_reg   <= cfg.nz * cfg.pz;
            b0_reg   <= bnx1_reg * bpx1_reg;
            b1_reg   <= bny1_reg * bpy1_reg;
            b2_reg   <= bnz1_reg * bpz1_reg;
        end
    end

    // Stage 3: sums.
    always_ff @(posedge aclk) begin
        if (en) begin
            bnx3_reg <= bnx2_reg;
            bny3_reg <= bny2_reg;
            bnz3_reg <= bnz2_reg;
            ux3_reg  <= ppi_pkg::DW'(c0_reg) - ppi_pkg::DW'(c1_reg);
            uy3_reg  <= ppi_pkg::DW'(c2_reg) - ppi_pkg::DW'(c3_reg);
            uz3_reg  <= ppi_pkg::DW'(c4_reg) - ppi_pkg::DW'(c5_reg);
            dot3_reg <= (2*ppi_pkg::CW+3)'(t0_reg) + (2*ppi_pkg::CW+3)'(t1_reg)
                      + (2*ppi_pkg::CW+3)'(t2_reg);
            d1_3_reg <= -(ppi_pkg::DDW'(a0_reg) + ppi_pkg::DDW'(a1_reg)
                        + ppi_pkg::DDW'(a2_reg));
            d2_3_reg <= -(ppi_pkg::DDW'(b0_reg) + ppi_pkg::DDW'(b1_reg)
                        + ppi_pkg::DDW'(b2_reg));
        end
    end

    // Classification: parallel test, pivot axis and numerator operands.
    logic [ppi_pkg::DW-1:0]  mx, my, mz;
    logic [ppi_pkg::DW+1:0]  msum;
    logic                    parallel;

    always_comb begin
        mx       = ux3_reg[ppi_pkg::DW-1] ? ppi_pkg::DW'(-ux3_reg) : ppi_pkg::DW'(ux3_reg);
        my       = uy3_reg[ppi_pkg::DW-1] ? ppi_pkg::DW'(-uy3_reg) : ppi_pkg::DW'(uy3_reg);
        mz       = uz3_reg[ppi_pkg::DW-1] ? ppi_pkg::DW'(-uz3_reg) : ppi_pkg::DW'(uz3_reg);
        msum     = (ppi_pkg::DW+2)'(mx) + (ppi_pkg::DW+2)'(my) + (ppi_pkg::DW+2)'(mz);
        parallel = msum < (ppi_pkg::DW+2)'(cfg.thr);

        out_item.ux = ux3_reg;
        out_item.uy = uy3_reg;
        out_item.uz = uz3_reg;
        if (parallel) begin
            out_item.rel = (dot3_reg == '0) ? ppi_pkg::REL_COINCIDENT
                                            : ppi_pkg::REL_DISJOINT;
        end else begin
            out_item.rel = ppi_pkg::REL_LINE;
        end

        // Ties go to the later axis.
        if (mx > my && mx > mz) begin
            out_item.axis = ppi_pkg::AXIS_X;
            out_item.den  = ux3_reg;
            out_item.d0a  = d2_3_reg;
            out_item.n0a  = cfg.nz;
            out_item.d0b  = d1_3_reg;
            out_item.n0b  = bnz3_reg;
            out_item.d1a  = d1_3_reg;
            out_item.n1a  = bny3_reg;
            out_item.d1b  = d2_3_reg;
            out_item.n1b  = cfg.ny;
        end else if (my > mz) begin
            out_item.axis = ppi_pkg::AXIS_Y;
            out_item.den  = uy3_reg;
            out_item.d0a  = d1_3_reg;
            out_item.n0a  = bnz3_reg;
            out_item.d0b  = d2_3_reg;
            out_item.n0b  = cfg.nz;
            out_item.d1a  = d2_3_reg;
            out_item.n1a  = cfg.nx;
            out_item.d1b  = d1_3_reg;
            out_item.n1b  = bnx3_reg;
        end else begin
            out_item.axis = ppi_pkg::AXIS_Z;
            out_item.den  = uz3_reg;
            out_item.d0a  = d2_3_reg;
            out_item.n0a  = cfg.ny;
            out_item.d0b  = d1_3_reg;
            out_item.n0b  = bny3_reg;
            out_item.d1a  = d1_3_reg;
            out_item.n1a  = bnx3_reg;
            out_item.d1b  = d2_3_reg;
            out_item.n1b  = cfg.nx;
        end
    end

    assign out_valid = v3_reg;

endmodule

// ----- rtl/ppi_queue.sv -----
`timescale 1ns / 1ps

module ppi_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push_valid,
    output logic               push_ready,
    input  ppi_pkg::ppi_item_t push_item,
    output logic               pop_valid,
    input  logic               pop_ready,
    output ppi_pkg::ppi_item_t pop_item
);

    ppi_pkg::ppi_item_t          mem [ppi_pkg::QDEPTH];
    logic [ppi_pkg::QAW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [ppi_pkg::QAW:0]       count_reg;
    logic                        push, pop;

    assign push_ready = count_reg != (ppi_pkg::QAW+1)'(ppi_pkg::QDEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = mem[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/ppi_div.sv -----
`timescale 1ns / 1ps

module ppi_div (
    input  logic                          aclk,
    input  logic                          en,
    input  logic signed [ppi_pkg::NW-1:0] num_i,
    input  logic signed [ppi_pkg::DW-1:0] den_i,
    output logic signed [ppi_pkg::PW-1:0] quo_o
);

    localparam int NM = ppi_pkg::NMAG;
    localparam int DM = ppi_pkg::DMAG;
    localparam logic [NM-1:0] LIM = NM'(1) << (ppi_pkg::PW - 1);

    logic [NM-1:0] qn_reg  [NM+1];
    logic [DM-1:0] rem_reg [NM+1];
    logic [DM-1:0] dm_reg  [NM+1];
    logic          neg_reg [NM+1];
    logic          dz_reg  [NM+1];
    logic [DM:0]   step    [NM+1];

    logic [ppi_pkg::NW-1:0] num_abs;
    logic [ppi_pkg::DW-1:0] den_abs;

    // One restoring step: the top bit is the quotient bit, the rest the remainder.
    function automatic logic [DM:0] div_step(input logic [DM-1:0] rem, input logic nb,
                                             input logic [DM-1:0] dm);
        logic [DM:0] trial;
        logic [DM:0] diff;
        trial = {rem, nb};
        diff  = trial - {1'b0, dm};
        if (trial >= {1'b0, dm}) begin
            return {1'b1, diff[DM-1:0]};
        end
        return {1'b0, trial[DM-1:0]};
    endfunction

    // Operand magnitudes; the sign of the truncated quotient is taken in the entry stage.
    always_comb begin
        num_abs = num_i[ppi_pkg::NW-1] ? ppi_pkg::NW'(-num_i) : ppi_pkg::NW'(num_i);
        den_abs = den_i[ppi_pkg::DW-1] ? ppi_pkg::DW'(-den_i) : ppi_pkg::DW'(den_i);
    end

    // Trial subtraction of every stage.
    always_comb begin
        step[0] = '0;
        for (int i = 1; i <= NM; i++) begin
            step[i] = div_step(rem_reg[i-1], qn_reg[i-1][NM-1], dm_reg[i-1]);
        end
    end

    // Entry stage and one restoring step per stage; the dividend shifts out
    // of qn as the quotient bits shift in.
    always_ff @(posedge aclk) begin
        if (en) begin
            qn_reg[0]  <= num_abs[NM-1:0];
            rem_reg[0] <= '0;
            dm_reg[0]  <= den_abs[DM-1:0];
            neg_reg[0] <= num_i[ppi_pkg::NW-1] ^ den_i[ppi_pkg::DW-1];
            dz_reg[0]  <= den_i == '0;
            for (int i = 1; i <= NM; i++) begin
                rem_reg[i] <= step[i][DM-1:0];
                qn_reg[i]  <= {qn_reg[i-1][NM-2:0], step[i][DM]};
                dm_reg[i]  <= dm_reg[i-1];
                neg_reg[i] <= neg_reg[i-1];
                dz_reg[i]  <= dz_reg[i-1];
            end
        end
    end

    // Sign, saturation to 32 bits and the zero-divisor case.
    always_ff @(posedge aclk) begin
        if (en) begin
            if (dz_reg[NM]) begin
                quo_o <= '0;
            end else if (neg_reg[NM]) begin
                if (qn_reg[NM] > LIM) begin
                    quo_o <= {1'b1, {(ppi_pkg::PW-1){1'b0}}};
                end else begin
                    quo_o <= -$signed(qn_reg[NM][ppi_pkg::PW-1:0]);
                end
            end else begin
                if (qn_reg[NM] >= LIM) begin
                    quo_o <= {1'b0, {(ppi_pkg::PW-1){1'b1}}};
                end else begin
                    quo_o <= $signed(qn_reg[NM][ppi_pkg::PW-1:0]);
                end
            end
        end
    end

endmodule

// ----- rtl/ppi_back.sv -----
`timescale 1ns / 1ps

module ppi_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  ppi_pkg::ppi_item_t             in_item,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [1:0]                     out_relation,
    output logic signed [ppi_pkg::PW-1:0]  out_px,
    output logic signed [ppi_pkg::PW-1:0]  out_py,
    output logic signed [ppi_pkg::PW-1:0]  out_pz,
    output logic signed [ppi_pkg::DW-1:0]  out_dx,
    output logic signed [ppi_pkg::DW-1:0]  out_dy,
    output logic signed [ppi_pkg::DW-1:0]  out_dz
);

    logic en;
    logic v1_reg, v2_reg, ov_reg;
    logic vd_reg [ppi_pkg::DIV_LAT];

    ppi_pkg::ppi_side_t side1_reg, side2_reg;
    ppi_pkg::ppi_side_t sided_reg [ppi_pkg::DIV_LAT];

    logic signed [ppi_pkg::PRW-1:0] p0a_reg, p0b_reg, p1a_reg, p1b_reg;
    logic signed [ppi_pkg::DW-1:0]  den1_reg, den2_reg;
    logic signed [ppi_pkg::NW-1:0]  num0_reg, num1_reg;
    logic signed [ppi_pkg::PW-1:0]  q0, q1;

    // The back advances as one pipeline whenever the output register drains.
    assign en       = !ov_reg || out_ready;
    assign in_ready = en;

    // Numerator products, then their differences.
    always_ff @(posedge aclk) begin
        if (en) begin
            side1_reg <= '{rel: in_item.rel, axis: in_item.axis,
                           ux: in_item.ux, uy: in_item.uy, uz: in_item.uz};
            den1_reg  <= in_item.den;
            p0a_reg   <= in_item.d0a * in_item.n0a;
            p0b_reg   <= in_item.d0b * in_item.n0b;
            p1a_reg   <= in_item.d1a * in_item.n1a;
            p1b_reg   <= in_item.d1b * in_item.n1b;
            side2_reg <= side1_reg;
            den2_reg  <= den1_reg;
            num0_reg  <= ppi_pkg::NW'(p0a_reg) - ppi_pkg::NW'(p0b_reg);
            num1_reg  <= ppi_pkg::NW'(p1a_reg) - ppi_pkg::NW'(p1b_reg);
        end
    end

    ppi_div u_div0 (
        .aclk  (aclk),
        .en    (en),
        .num_i (num0_reg),
        .den_i (den2_reg),
        .quo_o (q0)
    );

    ppi_div u_div1 (
        .aclk  (aclk),
        .en    (en),
        .num_i (num1_reg),
        .den_i (den2_reg),
        .quo_o (q1)
    );

    // Side data delay line, matched to the divider latency.
    always_ff @(posedge aclk) begin
        if (en) begin
            sided_reg[0] <= side2_reg;
            for (int i = 1; i < ppi_pkg::DIV_LAT; i++) begin
                sided_reg[i] <= sided_reg[i-1];
            end
        end
    end

    // Valid bits of every stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            ov_reg <= 1'b0;
            for (int i = 0; i < ppi_pkg::DIV_LAT; i++) begin
                vd_reg[i] <= 1'b0;
            end
        end else if (en) begin
            v1_reg    <= in_valid;
            v2_reg    <= v1_reg;
            vd_reg[0] <= v2_reg;
            for (int i = 1; i < ppi_pkg::DIV_LAT; i++) begin
                vd_reg[i] <= vd_reg[i-1];
            end
            ov_reg <= vd_reg[ppi_pkg::DIV_LAT-1];
        end
    end

    // Output register: place the quotients by pivot axis, zero when parallel.
    ppi_pkg::ppi_side_t sl;
    assign sl = sided_reg[ppi_pkg::DIV_LAT-1];

    always_ff @(posedge aclk) begin
        if (en) begin
            out_relation <= sl.rel;
            out_px       <= '0;
            out_py       <= '0;
            out_pz       <= '0;
            out_dx       <= '0;
            out_dy       <= '0;
            out_dz       <= '0;
            if (sl.rel == ppi_pkg::REL_LINE) begin
                out_dx <= sl.ux;
                out_dy <= sl.uy;
                out_dz <= sl.uz;
                case (sl.axis)
                    ppi_pkg::AXIS_X: begin
                        out_py <= q0;
                        out_pz <= q1;
                    end
                    ppi_pkg::AXIS_Y: begin
                        out_px <= q0;
                        out_pz <= q1;
                    end
                    default: begin
                        out_px <= q0;
                        out_py <= q1;
                    end
                endcase
            end
        end
    end

    assign out_valid = ov_reg;

endmodule

// ----- rtl/plane_plane_intersection.sv -----
`timescale 1ns / 1ps

// Intersects a reference plane, set through the APB registers, with one input
// plane per transfer and returns the relation, a point on the line and the
// line direction. The block takes one transfer per clock cycle when the
// result side is ready; a transfer goes through three front stages, the
// queue, two numerator stages, the two pipelined dividers of 50 one-bit
// restoring stages plus entry and saturation stages, and the output register.
// The front stalls only when the four-entry queue is full, the back only when
// its output register is held. No clearing pass follows reset. Configuration
// must be written only while no transfer is in flight; it is not enforced.

module plane_plane_intersection #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ppi_pkg::AW-1:0]        paddr,
    input  logic [ppi_pkg::RW-1:0]        pwdata,
    output logic [ppi_pkg::RW-1:0]        prdata,
    output logic                          pready,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [15:0]            s_other_point_x,
    input  logic signed [15:0]            s_other_point_y,
    input  logic signed [15:0]            s_other_point_z,
    input  logic signed [15:0]            s_other_normal_x,
    input  logic signed [15:0]            s_other_normal_y,
    input  logic signed [15:0]            s_other_normal_z,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_relation,
    output logic signed [31:0]            m_line_point_x,
    output logic signed [31:0]            m_line_point_y,
    output logic signed [31:0]            m_line_point_z,
    output logic signed [32:0]            m_line_dir_x,
    output logic signed [32:0]            m_line_dir_y,
    output logic signed [32:0]            m_line_dir_z
);

    localparam int CWE = (COORD_WIDTH > ppi_pkg::CW) ? ppi_pkg::CW : COORD_WIDTH;
    localparam int SH  = ppi_pkg::CW - CWE;

    // Configuration registers.
    logic [ppi_pkg::CW-1:0]  ref_px_reg, ref_py_reg, ref_pz_reg;
    logic [ppi_pkg::CW-1:0]  ref_nx_reg, ref_ny_reg, ref_nz_reg;
    logic [ppi_pkg::THW-1:0] thr_reg;
    logic                    wr_en;
    logic [2:0]              reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ppi_pkg::AW-1:3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_px_reg <= '0;
            ref_py_reg <= '0;
            ref_pz_reg <= '0;
            ref_nx_reg <= '0;
            ref_ny_reg <= '0;
            ref_nz_reg <= ppi_pkg::CW'(256);
            thr_reg    <= ppi_pkg::THW'(1);
        end else if (wr_en) begin
            unique case (reg_idx)
                ppi_pkg::REG_REF_POINT_X:  ref_px_reg <= pwdata[ppi_pkg::CW-1:0];
                ppi_pkg::REG_REF_POINT_Y:  ref_py_reg <= pwdata[ppi_pkg::CW-1:0];
                ppi_pkg::REG_REF_POINT_Z:  ref_pz_reg <= pwdata[ppi_pkg::CW-1:0];
                ppi_pkg::REG_REF_NORMAL_X: ref_nx_reg <= pwdata[ppi_pkg::CW-1:0];
                ppi_pkg::REG_REF_NORMAL_Y: ref_ny_reg <= pwdata[ppi_pkg::CW-1:0];
                ppi_pkg::REG_REF_NORMAL_Z: ref_nz_reg <= pwdata[ppi_pkg::CW-1:0];
                ppi_pkg::REG_THRESHOLD:    thr_reg    <= pwdata[ppi_pkg::THW-1:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        unique case (reg_idx)
            ppi_pkg::REG_REF_POINT_X:  prdata = ppi_pkg::RW'(ref_px_reg);
            ppi_pkg::REG_REF_POINT_Y:  prdata = ppi_pkg::RW'(ref_py_reg);
            ppi_pkg::REG_REF_POINT_Z:  prdata = ppi_pkg::RW'(ref_pz_reg);
            ppi_pkg::REG_REF_NORMAL_X: prdata = ppi_pkg::RW'(ref_nx_reg);
            ppi_pkg::REG_REF_NORMAL_Y: prdata = ppi_pkg::RW'(ref_ny_reg);
            ppi_pkg::REG_REF_NORMAL_Z: prdata = ppi_pkg::RW'(ref_nz_reg);
            ppi_pkg::REG_THRESHOLD:    prdata = ppi_pkg::RW'(thr_reg);
            default:                   prdata = '0;
        endcase
    end

    // Coordinates are sign-extended from the configured width.
    function automatic logic signed [ppi_pkg::CW-1:0] sext(input logic [ppi_pkg::CW-1:0] v);
        logic signed [ppi_pkg::CW-1:0] t;
        t = $signed(v << SH);
        return t >>> SH;
    endfunction

    ppi_pkg::ppi_ref_t cfg;

    always_comb begin
        cfg.px  = sext(ref_px_reg);
        cfg.py  = sext(ref_py_reg);
        cfg.pz  = sext(ref_pz_reg);
        cfg.nx  = sext(ref_nx_reg);
        cfg.ny  = sext(ref_ny_reg);
        cfg.nz  = sext(ref_nz_reg);
        cfg.thr = thr_reg;
    end

    // Front, queue and back.
    logic               f_valid, f_ready, q_valid, q_ready;
    ppi_pkg::ppi_item_t f_item, q_item;

    ppi_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .bpx       (sext(s_other_point_x)),
        .bpy       (sext(s_other_point_y)),
        .bpz       (sext(s_other_point_z)),
        .bnx       (sext(s_other_normal_x)),
        .bny       (sext(s_other_normal_y)),
        .bnz       (sext(s_other_normal_z)),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_item  (f_item)
    );

    ppi_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_item  (f_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_item   (q_item)
    );

    ppi_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (q_valid),
        .in_ready     (q_ready),
        .in_item      (q_item),
        .out_valid    (m_valid),
        .out_ready    (m_ready),
        .out_relation (m_relation),
        .out_px       (m_line_point_x),
        .out_py       (m_line_point_y),
        .out_pz       (m_line_point_z),
        .out_dx       (m_line_dir_x),
        .out_dy       (m_line_dir_y),
        .out_dz       (m_line_dir_z)
    );

    // A parallel result carries neither a point nor a direction.
    a_parallel_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_relation != ppi_pkg::REL_LINE |->
            m_line_dir_x == '0 && m_line_dir_y == '0 && m_line_dir_z == '0 &&
            m_line_point_x == '0 && m_line_point_y == '0 && m_line_point_z == '0)
        else $error("parallel result with nonzero point or direction");

    // A line with a zero direction came through a zero divisor.
    a_zero_div: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_relation == ppi_pkg::REL_LINE && m_line_dir_x == '0 &&
        m_line_dir_y == '0 && m_line_dir_z == '0 |->
            m_line_point_x == '0 && m_line_point_y == '0 && m_line_point_z == '0)
        else $error("zero divisor gave a nonzero point");

    // No result is presented right after reset.
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Relation code three is never produced.
    a_rel_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_relation == ppi_pkg::REL_DISJOINT ||
            m_relation == ppi_pkg::REL_COINCIDENT || m_relation == ppi_pkg::REL_LINE)
        else $error("undefined relation code");

endmodule

// ----- tb/ppi_checker.sv -----
`timescale 1ns / 1ps

// Watches both channels of the plane intersection block, predicts each result
// from the accepted input planes and the current reference plane, and compares.
module ppi_checker (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic signed [15:0]   ref_px,
    input  logic signed [15:0]   ref_py,
    input  logic signed [15:0]   ref_pz,
    input  logic signed [15:0]   ref_nx,
    input  logic signed [15:0]   ref_ny,
    input  logic signed [15:0]   ref_nz,
    input  logic [32:0]          ref_thr,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic signed [15:0]   s_other_point_x,
    input  logic signed [15:0]   s_other_point_y,
    input  logic signed [15:0]   s_other_point_z,
    input  logic signed [15:0]   s_other_normal_x,
    input  logic signed [15:0]   s_other_normal_y,
    input  logic signed [15:0]   s_other_normal_z,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic [1:0]           m_relation,
    input  logic signed [31:0]   m_line_point_x,
    input  logic signed [31:0]   m_line_point_y,
    input  logic signed [31:0]   m_line_point_z,
    input  logic signed [32:0]   m_line_dir_x,
    input  logic signed [32:0]   m_line_dir_y,
    input  logic signed [32:0]   m_line_dir_z,
    output int                   fail_count,
    output int                   pending
);

    typedef struct packed {
        logic [1:0]         rel;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic signed [32:0] dz;
    } line_result_t;

    line_result_t expected_lines[$];

    // Divide with truncation toward zero, then clamp to 32 bits.
    function automatic logic signed [31:0] clamp_quot(longint num, longint den);
        longint q;
        if (den == 0) begin
            return '0;
        end
        q = num / den;
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        if (q < -64'sd2147483648) q = -64'sd2147483648;
        return q[31:0];
    endfunction

    function automatic line_result_t intersect_planes(
        longint bx, longint by, longint bz, longint bn0, longint bn1, longint bn2);
        line_result_t r;
        longint ax, ay, az, an0, an1, an2;
        longint ux, uy, uz, mx, my, mz, d1, d2, dot;
        ax = ref_px; ay = ref_py; az = ref_pz;
        an0 = ref_nx; an1 = ref_ny; an2 = ref_nz;
        r = '0;
        ux = an1 * bn2 - an2 * bn1;
        uy = an2 * bn0 - an0 * bn2;
        uz = an0 * bn1 - an1 * bn0;
        mx = ux < 0 ? -ux : ux;
        my = uy < 0 ? -uy : uy;
        mz = uz < 0 ? -uz : uz;
        if (mx + my + mz < longint'({31'd0, ref_thr})) begin
            dot = an0 * (bx - ax) + an1 * (by - ay) + an2 * (bz - az);
            r.rel = (dot == 0) ? ppi_pkg::REL_COINCIDENT : ppi_pkg::REL_DISJOINT;
            return r;
        end
        d1 = -(an0 * ax + an1 * ay + an2 * az);
        d2 = -(bn0 * bx + bn1 * by + bn2 * bz);
        // The axis with the largest direction component is set to zero.
        if (mx > my && mx > mz) begin
            r.py = clamp_quot(d2 * an2 - d1 * bn2, ux);
            r.pz = clamp_quot(d1 * bn1 - d2 * an1, ux);
        end else if (my > mz) begin
            r.px = clamp_quot(d1 * bn2 - d2 * an2, uy);
            r.pz = clamp_quot(d2 * an0 - d1 * bn0, uy);
        end else begin
            r.px = clamp_quot(d2 * an1 - d1 * bn1, uz);
            r.py = clamp_quot(d1 * bn0 - d2 * an0, uz);
        end
        r.rel = ppi_pkg::REL_LINE;
        r.dx = ux[32:0];
        r.dy = uy[32:0];
        r.dz = uz[32:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("Mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    // Predict on every input transfer, compare on every result transfer.
    always @(posedge aclk) begin
        line_result_t e;
        if (aresetn && s_valid && s_ready) begin
            expected_lines.push_back(intersect_planes(s_other_point_x, s_other_point_y,
                s_other_point_z, s_other_normal_x, s_other_normal_y, s_other_normal_z));
        end
        if (aresetn && m_valid && m_ready) begin
            if (expected_lines.size() == 0) begin
                report_mismatch("unexpected result, relation", m_relation, -1);
            end else begin
                e = expected_lines.pop_front();
                if (m_relation !== e.rel) report_mismatch("relation", m_relation, e.rel);
                if (m_line_point_x !== e.px) report_mismatch("point x", m_line_point_x, e.px);
                if (m_line_point_y !== e.py) report_mismatch("point y", m_line_point_y, e.py);
                if (m_line_point_z !== e.pz) report_mismatch("point z", m_line_point_z, e.pz);
                if (m_line_dir_x !== e.dx) report_mismatch("dir x", m_line_dir_x, e.dx);
                if (m_line_dir_y !== e.dy) report_mismatch("dir y", m_line_dir_y, e.dy);
                if (m_line_dir_z !== e.dz) report_mismatch("dir z", m_line_dir_z, e.dz);
            end
        end
        pending = expected_lines.size();
    end

endmodule

// ----- tb/tb_plane_plane_intersection.sv -----
`timescale 1ns / 1ps

module tb_plane_plane_intersection;

    localparam int CYCLE_LIMIT = 900000;

    logic aclk;
    logic aresetn;
    logic psel, penable, pwrite;
    logic [ppi_pkg::AW-1:0] paddr;
    logic [ppi_pkg::RW-1:0] pwdata;
    logic [ppi_pkg::RW-1:0] prdata;
    logic pready;
    logic s_valid, s_ready;
    logic signed [15:0] s_px, s_py, s_pz, s_nx, s_ny, s_nz;
    logic m_valid, m_ready;
    logic [1:0] m_relation;
    logic signed [31:0] m_ptx, m_pty, m_ptz;
    logic signed [32:0] m_dx, m_dy, m_dz;

    // Shadow of the reference plane registers, used by the checker.
    logic signed [15:0] ref_px, ref_py, ref_pz, ref_nx, ref_ny, ref_nz;
    logic [32:0] ref_thr;

    int fail_count;
    int pending;
    int cycle_count;
    bit long_hold;

    plane_plane_intersection uut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_other_point_x(s_px), .s_other_point_y(s_py), .s_other_point_z(s_pz),
        .s_other_normal_x(s_nx), .s_other_normal_y(s_ny), .s_other_normal_z(s_nz),
        .m_valid(m_valid), .m_ready(m_ready), .m_relation(m_relation),
        .m_line_point_x(m_ptx), .m_line_point_y(m_pty), .m_line_point_z(m_ptz),
        .m_line_dir_x(m_dx), .m_line_dir_y(m_dy), .m_line_dir_z(m_dz)
    );

    ppi_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .ref_px(ref_px), .ref_py(ref_py), .ref_pz(ref_pz),
        .ref_nx(ref_nx), .ref_ny(ref_ny), .ref_nz(ref_nz), .ref_thr(ref_thr),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_other_point_x(s_px), .s_other_point_y(s_py), .s_other_point_z(s_pz),
        .s_other_normal_x(s_nx), .s_other_normal_y(s_ny), .s_other_normal_z(s_nz),
        .m_valid(m_valid), .m_ready(m_ready), .m_relation(m_relation),
        .m_line_point_x(m_ptx), .m_line_point_y(m_pty), .m_line_point_z(m_ptz),
        .m_line_dir_x(m_dx), .m_line_dir_y(m_dy), .m_line_dir_z(m_dz),
        .fail_count(fail_count), .pending(pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog on total run length.
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Writes one register through a setup and an access cycle.
    task automatic write_reg(logic [2:0] idx, logic [ppi_pkg::RW-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ppi_pkg::AW'(idx) << 3;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            ppi_pkg::REG_REF_POINT_X:  ref_px <= value[15:0];
            ppi_pkg::REG_REF_POINT_Y:  ref_py <= value[15:0];
            ppi_pkg::REG_REF_POINT_Z:  ref_pz <= value[15:0];
            ppi_pkg::REG_REF_NORMAL_X: ref_nx <= value[15:0];
            ppi_pkg::REG_REF_NORMAL_Y: ref_ny <= value[15:0];
            ppi_pkg::REG_REF_NORMAL_Z: ref_nz <= value[15:0];
            ppi_pkg::REG_THRESHOLD:    ref_thr <= value[32:0];
            default: ;
        endcase
    endtask

    task automatic set_reference(logic signed [15:0] px, logic signed [15:0] py,
        logic signed [15:0] pz, logic signed [15:0] nx, logic signed [15:0] ny,
        logic signed [15:0] nz, logic [32:0] thr);
        write_reg(ppi_pkg::REG_REF_POINT_X, ppi_pkg::RW'(px));
        write_reg(ppi_pkg::REG_REF_POINT_Y, ppi_pkg::RW'(py));
        write_reg(ppi_pkg::REG_REF_POINT_Z, ppi_pkg::RW'(pz));
        write_reg(ppi_pkg::REG_REF_NORMAL_X, ppi_pkg::RW'(nx));
        write_reg(ppi_pkg::REG_REF_NORMAL_Y, ppi_pkg::RW'(ny));
        write_reg(ppi_pkg::REG_REF_NORMAL_Z, ppi_pkg::RW'(nz));
        write_reg(ppi_pkg::REG_THRESHOLD, ppi_pkg::RW'(thr));
    endtask

    // Stops offering and waits until the pipeline has returned every result.
    task automatic drain_pipeline();
        s_valid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (ppi_pkg::DIV_LAT + 20) @(posedge aclk);
    endtask

    // Offers one plane, after a random gap, and waits for its transfer.
    // Valid stays high after the transfer so that the next plane can follow
    // without a gap.
    task automatic send_plane(logic signed [15:0] px, logic signed [15:0] py,
        logic signed [15:0] pz, logic signed [15:0] nx, logic signed [15:0] ny,
        logic signed [15:0] nz, bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 12);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_px <= px; s_py <= py; s_pz <= pz;
        s_nx <= nx; s_ny <= ny; s_nz <= nz;
        do @(posedge aclk); while (!s_ready);
    endtask

    function automatic logic signed [15:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 16'sh7fff;
            1: return -16'sh8000;
            2: return 16'($signed($urandom_range(0, 1024)) - 512);
            default: return 16'($urandom);
        endcase
    endfunction

    // Normal of the reference plane, scaled by a small factor, or a
    // perturbation of it, so that parallel cases come up often.
    task automatic send_random(int mode, bit no_gap);
        logic signed [15:0] nx, ny, nz, px, py, pz;
        int k;
        px = rand_coord(); py = rand_coord(); pz = rand_coord();
        if (mode == 0) begin
            k = $urandom_range(0, 4) - 2;
            nx = 16'(ref_nx * k); ny = 16'(ref_ny * k); nz = 16'(ref_nz * k);
            if ($urandom_range(0, 1) == 1) begin
                // Point on the reference plane for a coincident result.
                px = ref_px; py = ref_py; pz = ref_pz;
            end
            if ($urandom_range(0, 2) == 0) nx = nx + 16'($urandom_range(0, 2)) - 16'sd1;
        end else begin
            nx = rand_coord(); ny = rand_coord(); nz = rand_coord();
        end
        send_plane(px, py, pz, nx, ny, nz, no_gap);
    endtask

    // Result side: a random stall per result, with one long hold-off.
    initial begin
        int stall;
        m_ready <= 1'b0;
        wait (aresetn);
        forever begin
            if (long_hold) begin
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
                long_hold = 1'b0;
            end
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready) && !long_hold);
        end
    end

    initial begin
        int burst;
        aresetn <= 1'b0;
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        paddr <= '0; pwdata <= '0;
        s_valid <= 1'b0;
        s_px <= '0; s_py <= '0; s_pz <= '0;
        s_nx <= '0; s_ny <= '0; s_nz <= '0;
        ref_px <= '0; ref_py <= '0; ref_pz <= '0;
        ref_nx <= '0; ref_ny <= '0; ref_nz <= 16'sd256;
        ref_thr <= 33'd1;
        long_hold = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed planes against the reset reference plane z = 0.
        send_plane(0, 0, 0, 0, 0, 256, 0);
        send_plane(0, 0, 256, 0, 0, -256, 0);
        send_plane(0, 0, 0, 256, 0, 0, 0);
        send_plane(100, 0, 0, 0, 256, 0, 0);
        send_plane(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 0);
        send_plane(-16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000, 1, 0);
        send_plane(16'sh7fff, -16'sh8000, 0, 1, 1, 0, 0);
        send_plane(-16'sh8000, 16'sh7fff, 3, 1, -1, 5, 0);
        drain_pipeline();

        // Zero threshold and large-magnitude reference: zero divisor, saturation.
        set_reference(16'sh7fff, -16'sh8000, 16'sh7fff, -16'sh8000, 16'sh7fff, 1, 33'd0);
        send_plane(0, 0, 0, 0, 0, 0, 0);
        send_plane(-16'sh8000, -16'sh8000, -16'sh8000, 1, 0, 0, 0);
        send_plane(16'sh7fff, 16'sh7fff, 16'sh7fff, 0, 1, 1, 0);
        send_plane(0, 0, 0, -16'sh8000, 16'sh7fff, 1, 0);
        send_plane(5, 5, 5, 16'sh7fff, -16'sh8000, 16'sh7fff, 0);
        drain_pipeline();

        // Maximal threshold: every pair reads as parallel.
        set_reference(-16'sh8000, 16'sh7fff, -16'sh8000, 16'sh7fff, -16'sh8000, -16'sh8000,
            33'h1_8000_0000);
        send_plane(-16'sh8000, 16'sh7fff, -16'sh8000, 3, 4, 5, 0);
        send_plane(1, 2, 3, -16'sh8000, -16'sh8000, -16'sh8000, 0);
        send_plane(0, 0, 0, 16'sh7fff, 16'sh7fff, 16'sh7fff, 0);
        drain_pipeline();

        // Random phases, each with a fresh reference plane.
        for (int phase = 0; phase < 6; phase++) begin
            if (phase == 5) begin
                set_reference(0, 0, 0, 0, 0, 0, 33'h1_ffff_ffff);
            end else begin
                set_reference(rand_coord(), rand_coord(), rand_coord(),
                    16'($urandom_range(0, 600)) - 16'sd300, rand_coord(), rand_coord(),
                    phase == 0 ? 33'd0 : 33'($urandom_range(0, 1 << 16)));
            end
            for (int i = 0; i < 280; i++) begin
                send_random($urandom_range(0, 3) == 0 ? 0 : 1, 1'b0);
            end
            if (phase == 2) begin
                // Hold the result side while a burst fills the pipeline.
                long_hold = 1'b1;
                for (int i = 0; i < 100; i++) send_random(1, 1'b1);
            end
            if (phase == 3) begin
                // Back-to-back burst without gaps.
                burst = 60;
                for (int i = 0; i < burst; i++) send_random(1, 1'b1);
            end
            drain_pipeline();
        end

        drain_pipeline();
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ----- plane_plane_intersection.f -----
rtl/ppi_pkg.sv
rtl/ppi_front.sv
rtl/ppi_queue.sv
rtl/ppi_div.sv
rtl/ppi_back.sv
rtl/plane_plane_intersection.sv
tb/ppi_checker.sv
tb/tb_plane_plane_intersection.sv
